// ===== hw/rtl/utf8vw_pkg.sv =====
// Shared types and byte-class constants for the UTF-8 display width counter.
package utf8vw_pkg;

    localparam int WIDTH_BITS_DEFAULT = 16;
    localparam int VIS_WIDTH_W = 16;

    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;

    // Continuation byte counts announced by each lead form.
    localparam logic [1:0] CONT_NONE = 2'd0;
    localparam logic [1:0] CONT_ONE  = 2'd1;
    localparam logic [1:0] CONT_TWO  = 2'd2;
    localparam logic [1:0] CONT_THREE = 2'd3;

    typedef struct packed {
        logic       is_nul;
        logic       is_ascii;
        logic       is_cont;
        logic       is_lead;
        logic [1:0] lead_cont;
    } byte_class_t;

endpackage

// ===== hw/rtl/utf8vw_decode.sv =====
// Byte classifier: end of string, ASCII, continuation and lead forms.
module utf8vw_decode (
    input  logic [7:0]               data_byte,
    output utf8vw_pkg::byte_class_t  cls
);

    always_comb begin
        cls.is_nul    = (data_byte == 8'h00);
        cls.is_ascii  = !data_byte[7] && (data_byte != 8'h00);
        cls.is_cont   = (data_byte[7:6] == utf8vw_pkg::CONT_TAG);
        cls.is_lead   = 1'b0;
        cls.lead_cont = utf8vw_pkg::CONT_NONE;
        if (data_byte[7:5] == utf8vw_pkg::LEAD2_TAG) begin
            cls.is_lead   = 1'b1;
            cls.lead_cont = utf8vw_pkg::CONT_ONE;
        end else if (data_byte[7:4] == utf8vw_pkg::LEAD3_TAG) begin
            cls.is_lead   = 1'b1;
            cls.lead_cont = utf8vw_pkg::CONT_TWO;
        end else if (data_byte[7:3] == utf8vw_pkg::LEAD4_TAG) begin
            cls.is_lead   = 1'b1;
            cls.lead_cont = utf8vw_pkg::CONT_THREE;
        end
    end

endmodule

// ===== hw/rtl/utf8vw_track.sv =====
// String state: pending continuations, saturating width and sticky error.
module utf8vw_track #(
    parameter int WIDTH_BITS = utf8vw_pkg::WIDTH_BITS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     step,
    input  utf8vw_pkg::byte_class_t  cls,
    output logic [WIDTH_BITS-1:0]    res_width,
    output logic                     res_malformed
);

    logic [1:0]            pend_reg, pend_next;
    logic [WIDTH_BITS-1:0] acc_reg, acc_next;
    logic                  err_reg, err_next;
    logic [WIDTH_BITS:0]   sum;
    logic [WIDTH_BITS-1:0] sat_sum;
    logic [1:0]            amount;

    assign amount  = cls.is_ascii ? 2'd1 : 2'd2;
    assign sum     = {1'b0, acc_reg} + {{(WIDTH_BITS-1){1'b0}}, amount};
    // A carry out means the sum passed the all-ones limit.
    assign sat_sum = sum[WIDTH_BITS] ? {WIDTH_BITS{1'b1}} : sum[WIDTH_BITS-1:0];

    assign res_malformed = err_reg || (pend_reg != utf8vw_pkg::CONT_NONE);
    assign res_width     = res_malformed ? '0 : acc_reg;

    always_comb begin
        pend_next = pend_reg;
        acc_next  = acc_reg;
        err_next  = err_reg;
        if (step) begin
            if (cls.is_nul) begin
                pend_next = utf8vw_pkg::CONT_NONE;
                acc_next  = '0;
                err_next  = 1'b0;
            end else if (err_reg) begin
                err_next = 1'b1;
            end else if (pend_reg != utf8vw_pkg::CONT_NONE) begin
                if (cls.is_cont) begin
                    pend_next = pend_reg - 2'd1;
                end else begin
                    err_next = 1'b1;
                end
            end else if (cls.is_ascii) begin
                acc_next = sat_sum;
            end else if (cls.is_lead) begin
                acc_next  = sat_sum;
                pend_next = cls.lead_cont;
            end else begin
                err_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= utf8vw_pkg::CONT_NONE;
            acc_reg  <= '0;
            err_reg  <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            acc_reg  <= acc_next;
            err_reg  <= err_next;
        end
    end

    a_nul_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && cls.is_nul |=> (acc_reg == '0) && (pend_reg == '0) && !err_reg)
        else $error("state not cleared after end of string");

    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg && step && !cls.is_nul |=> err_reg && $stable(acc_reg))
        else $error("error cleared or width moved before end of string");

    a_width_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !cls.is_nul |=> acc_reg >= $past(acc_reg))
        else $error("width decreased within a string");

endmodule

// ===== hw/rtl/utf8_visual_width_counter_unit.sv =====
// Top level: input register, byte classify and state update, result register.
// A NUL byte passes through the input register and then the result register; its
// result is valid on m_axis once it has been written into the result register.
// Throughput: one byte per cycle unless a NUL is held; the state update is a single
// classify and saturating add between the input register and the state registers.
// A NUL waits in the input register only while an earlier result is unclaimed.
// Reset (aresetn low, synchronous) empties both registers and clears the state.
module utf8_visual_width_counter_unit #(
    parameter int WIDTH_BITS = utf8vw_pkg::WIDTH_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [15:0] visual_width, [16] malformed, rest zero
);

    localparam int VW = utf8vw_pkg::VIS_WIDTH_W;

    logic                    in_valid_reg;
    logic [7:0]              in_byte_reg;
    logic                    out_valid_reg;
    logic [VW-1:0]           out_width_reg;
    logic                    out_mal_reg;
    utf8vw_pkg::byte_class_t cls;
    logic [WIDTH_BITS-1:0]   res_width;
    logic                    res_malformed;
    logic [WIDTH_BITS+VW-1:0] width_ext;
    logic                    out_free;
    logic                    step;

    utf8vw_decode u_decode (
        .data_byte (in_byte_reg),
        .cls       (cls)
    );

    utf8vw_track #(
        .WIDTH_BITS (WIDTH_BITS)
    ) u_track (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .cls           (cls),
        .res_width     (res_width),
        .res_malformed (res_malformed)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    // Only the end-of-string byte needs room in the result register.
    assign step          = in_valid_reg && (!cls.is_nul || out_free);
    assign s_axis_tready = !in_valid_reg || step;
    assign width_ext     = {{VW{1'b0}}, res_width};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step && cls.is_nul) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && cls.is_nul) begin
            out_width_reg <= width_ext[VW-1:0];
            out_mal_reg   <= res_malformed;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_mal_reg, out_width_reg};

    a_mal_zero_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[16] |-> (m_axis_tdata[15:0] == 16'h0000))
        else $error("malformed result carries a nonzero width");

endmodule
